@@ sv/m3inv_pkg.sv @@
// Shared constants and widths for the 3x3 cofactor matrix inverse.
package m3inv_pkg;

  localparam int ELEM_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int N_ELEM = 9;
  localparam int N_DIM  = 3;

  // Digit width of the partial-product multiplier and its latency.
  localparam int MUL_DIGIT = 32;
  localparam int MUL_LAT   = 3;

  // Cofactor front end latency.
  localparam int COF_LAT = 3;

  // Bit positions in the result tuser.
  localparam int USER_SINGULAR = 0;
  localparam int USER_OVERFLOW = 1;
  localparam int USER_W        = 2;

endpackage : m3inv_pkg

@@ sv/m3inv_dly.sv @@
// Enabled delay line that carries valid bits and sideband data along the pipeline.
module m3inv_dly import m3inv_pkg::*; #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] d_o
);

  logic [WIDTH-1:0] tap_q [DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < DEPTH; s++) begin
        tap_q[s] <= '0;
      end
    end else if (en_i) begin
      tap_q[0] <= d_i;
      for (int s = 1; s < DEPTH; s++) begin
        tap_q[s] <= tap_q[s-1];
      end
    end
  end

  assign d_o = tap_q[DEPTH-1];

endmodule : m3inv_dly

@@ sv/m3inv_mul.sv @@
// Pipelined unsigned multiplier built from registered digit partial products.
module m3inv_mul import m3inv_pkg::*; #(
  parameter int AW = 32,
  parameter int BW = 32
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [AW-1:0]   a_i,
  input  logic [BW-1:0]   b_i,
  output logic [AW+BW-1:0] p_o
);

  localparam int D   = MUL_DIGIT;
  localparam int NA  = (AW + D - 1) / D;
  localparam int NB  = (BW + D - 1) / D;
  localparam int RW  = (NB + 1) * D;
  localparam int PWM = (NA + NB) * D;

  logic [NA*D-1:0] a_x;
  logic [NB*D-1:0] b_x;
  logic [2*D-1:0]  pp_q  [NA][NB];
  logic [RW-1:0]   row_d [NA];
  logic [RW-1:0]   row_q [NA];
  logic [PWM-1:0]  prod_d;
  logic [PWM-1:0]  prod_q;

  assign a_x = (NA*D)'(a_i);
  assign b_x = (NB*D)'(b_i);

  // Stage one: every digit pair multiplied on its own.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_q[i][j] <= {{D{1'b0}}, a_x[i*D +: D]} * {{D{1'b0}}, b_x[j*D +: D]};
        end
      end
    end
  end

  // Stage two: one row sum per digit of a.
  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row_d[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_d[i] = row_d[i] + (RW'(pp_q[i][j]) << (j*D));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      row_q <= row_d;
    end
  end

  // Stage three: rows summed into the full product.
  always_comb begin
    prod_d = '0;
    for (int i = 0; i < NA; i++) begin
      prod_d = prod_d + (PWM'(row_q[i]) << (i*D));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign p_o = prod_q[AW+BW-1:0];

endmodule : m3inv_mul

@@ sv/m3inv_cof.sv @@
// Cofactor front end: the nine signed 2x2 minors, split into magnitude and sign.
module m3inv_cof import m3inv_pkg::*; #(
  parameter  int W  = ELEM_WIDTH_DEF,
  localparam int CW = 2 * W + 1
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic signed [W-1:0] m_i        [N_ELEM],
  output logic [CW-1:0]       c_abs_o    [N_ELEM],
  output logic [N_ELEM-1:0]   c_neg_o,
  output logic [W-1:0]        m0_abs_o   [N_DIM],
  output logic [N_DIM-1:0]    m0_neg_o
);

  logic signed [2*W-1:0] pa_q  [N_ELEM];
  logic signed [2*W-1:0] pb_q  [N_ELEM];
  logic signed [CW-1:0]  c_q   [N_ELEM];
  logic signed [W-1:0]   r0a_q [N_DIM];
  logic signed [W-1:0]   r0b_q [N_DIM];
  logic [CW-1:0]         cabs_q [N_ELEM];
  logic [N_ELEM-1:0]     cneg_q;
  logic [W-1:0]          m0abs_q [N_DIM];
  logic [N_DIM-1:0]      m0neg_q;

  for (genvar gi = 0; gi < N_DIM; gi++) begin : g_row
    for (genvar gj = 0; gj < N_DIM; gj++) begin : g_col
      localparam int I1 = (gi + 1) % N_DIM;
      localparam int I2 = (gi + 2) % N_DIM;
      localparam int J1 = (gj + 1) % N_DIM;
      localparam int J2 = (gj + 2) % N_DIM;
      localparam int K  = gi * N_DIM + gj;

      // The cyclic index order already carries the checkerboard sign.
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          pa_q[K]   <= m_i[I1*N_DIM+J1] * m_i[I2*N_DIM+J2];
          pb_q[K]   <= m_i[I1*N_DIM+J2] * m_i[I2*N_DIM+J1];
          c_q[K]    <= {pa_q[K][2*W-1], pa_q[K]} - {pb_q[K][2*W-1], pb_q[K]};
          cneg_q[K] <= c_q[K][CW-1];
          cabs_q[K] <= c_q[K][CW-1] ? CW'(-c_q[K]) : CW'(c_q[K]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < N_DIM; j++) begin
        r0a_q[j]   <= m_i[j];
        r0b_q[j]   <= r0a_q[j];
        m0neg_q[j] <= r0b_q[j][W-1];
        m0abs_q[j] <= r0b_q[j][W-1] ? W'(-r0b_q[j]) : W'(r0b_q[j]);
      end
    end
  end

  assign c_abs_o  = cabs_q;
  assign c_neg_o  = cneg_q;
  assign m0_abs_o = m0abs_q;
  assign m0_neg_o = m0neg_q;

endmodule : m3inv_cof

@@ sv/m3inv_div.sv @@
// Pipelined restoring divider: one quotient bit of 2^(QW-1) / divisor per stage.
module m3inv_div import m3inv_pkg::*; #(
  parameter int DW = 98,
  parameter int QW = 99
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [DW-1:0] dm_i,
  output logic [QW-1:0] q_o
);

  logic [DW-1:0] rem_q [QW];
  logic [DW-1:0] dm_q  [QW];
  logic [QW-1:0] q_q   [QW];

  for (genvar gs = 0; gs < QW; gs++) begin : g_stage
    localparam int K = QW - 1 - gs;
    logic [DW-1:0] rem_p;
    logic [DW-1:0] dm_p;
    logic [QW-1:0] q_p;
    logic [DW:0]   sh;
    logic          ge;

    if (gs == 0) begin : g_first
      assign rem_p = '0;
      assign dm_p  = dm_i;
      assign q_p   = '0;
    end else begin : g_next
      assign rem_p = rem_q[gs-1];
      assign dm_p  = dm_q[gs-1];
      assign q_p   = q_q[gs-1];
    end

    // The dividend is a single one at the top, brought down in the first stage.
    assign sh = {rem_p, (gs == 0) ? 1'b1 : 1'b0};
    assign ge = sh >= {1'b0, dm_p};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[gs] <= ge ? DW'(sh - {1'b0, dm_p}) : DW'(sh);
        dm_q[gs]  <= dm_p;
        q_q[gs]   <= q_p | (QW'(ge) << K);
      end
    end
  end

  assign q_o = q_q[QW-1];

endmodule : m3inv_div

@@ sv/mat3_inverse_cofactor.sv @@
// Top level of the pipelined 3x3 fixed-point matrix inverse by cofactors.
//
// One beat on the slave stream carries a whole matrix, nine signed
// Q(ELEM_WIDTH-FRAC_BITS).FRAC_BITS elements in row-major order. One beat
// on the master stream carries the inverse in the same layout, with the
// singular and overflow flags in tuser.
// A new matrix can enter in every cycle while s_axis_tready is high. Most of
// the pipeline is the reciprocal divider, which resolves one quotient bit per
// stage; the cofactor front end, the determinant sum and magnitude registers,
// the two digit-product multipliers, the result register and the output
// register make up the rest.
// A zero determinant gives an all-zero result with the singular flag set.
// Elements that fall outside the output range saturate and set the
// overflow flag.
// Reset empties the pipeline and the output register; no memory needs
// clearing. When the receiver stalls, the finished beat waits in the output
// register and one more beat is caught in a skid register; only then does
// s_axis_tready drop and the whole pipeline hold, losing nothing.
module mat3_inverse_cofactor import m3inv_pkg::*; #(
  parameter  int ELEM_WIDTH = ELEM_WIDTH_DEF,
  parameter  int FRAC_BITS  = FRAC_BITS_DEF,
  localparam int TDW        = ((N_ELEM * ELEM_WIDTH + 7) / 8) * 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // tdata fields from the lowest bit up: m00, m01, m02, m10, m11, m12, m20, m21, m22
  input  logic [TDW-1:0]    s_axis_tdata,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // tdata fields from the lowest bit up: r00, r01, r02, r10, r11, r12, r20, r21, r22
  output logic [TDW-1:0]    m_axis_tdata,
  // tuser fields from the lowest bit up: singular, overflowed
  output logic [USER_W-1:0] m_axis_tuser,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready
);

  localparam int W  = ELEM_WIDTH;
  localparam int CW = 2 * W + 1;            // cofactor magnitude
  localparam int DW = 3 * W + 2;            // determinant, signed
  localparam int QW = 2 * FRAC_BITS + 2 * W + 3;  // reciprocal
  localparam int SS = 2 * W + 2;            // scale shift
  localparam int PW = CW + QW;              // scaled product
  localparam int QS = PW - SS;              // product after the shift
  localparam int OW = N_ELEM * W;

  // Sideband layouts of the delay lines.
  localparam int S1 = 1 + N_DIM + N_ELEM + N_ELEM * CW;
  localparam int S2 = 2 + N_ELEM + N_ELEM * CW;
  localparam int S3 = 2 + N_ELEM;

  logic en;

  // Input unpack and cofactor front end.
  logic signed [W-1:0] m_in   [N_ELEM];
  logic [CW-1:0]       c_abs  [N_ELEM];
  logic [N_ELEM-1:0]   c_neg;
  logic [W-1:0]        m0_abs [N_DIM];
  logic [N_DIM-1:0]    m0_neg;
  logic                v1;

  for (genvar gk = 0; gk < N_ELEM; gk++) begin : g_unpack
    assign m_in[gk] = s_axis_tdata[gk*W +: W];
  end

  m3inv_cof #(.W(W)) u_cof (
    .clk_i    (clk_i),
    .en_i     (en),
    .m_i      (m_in),
    .c_abs_o  (c_abs),
    .c_neg_o  (c_neg),
    .m0_abs_o (m0_abs),
    .m0_neg_o (m0_neg)
  );

  m3inv_dly #(.WIDTH(1), .DEPTH(COF_LAT)) u_dly_cof (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .d_i    (s_axis_tvalid),
    .d_o    (v1)
  );

  // Determinant products: row 0 elements times their cofactors.
  logic [W+CW-1:0] dprod [N_DIM];
  logic [S1-1:0]   side1_d;
  logic [S1-1:0]   side1_q;

  for (genvar gj = 0; gj < N_DIM; gj++) begin : g_det_mul
    m3inv_mul #(.AW(W), .BW(CW)) u_mul (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   (m0_abs[gj]),
      .b_i   (c_abs[gj]),
      .p_o   (dprod[gj])
    );
  end

  always_comb begin
    side1_d = '0;
    side1_d[0]                = v1;
    side1_d[1 +: N_DIM]       = m0_neg;
    side1_d[1+N_DIM +: N_ELEM] = c_neg;
    for (int k = 0; k < N_ELEM; k++) begin
      side1_d[1+N_DIM+N_ELEM+k*CW +: CW] = c_abs[k];
    end
  end

  m3inv_dly #(.WIDTH(S1), .DEPTH(MUL_LAT)) u_dly_det (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .d_i    (side1_d),
    .d_o    (side1_q)
  );

  // Determinant sum with the signs put back.
  logic              v2;
  logic [N_DIM-1:0]  m0n2;
  logic [N_ELEM-1:0] cn2;
  logic [N_ELEM*CW-1:0] ca2;
  logic [DW-1:0]     det_d;
  logic [DW-1:0]     det_q;
  logic              vd_q;
  logic [N_ELEM-1:0] cnd_q;
  logic [N_ELEM*CW-1:0] cad_q;

  assign v2   = side1_q[0];
  assign m0n2 = side1_q[1 +: N_DIM];
  assign cn2  = side1_q[1+N_DIM +: N_ELEM];
  assign ca2  = side1_q[1+N_DIM+N_ELEM +: N_ELEM*CW];

  always_comb begin
    logic [DW-1:0] term;
    det_d = '0;
    for (int j = 0; j < N_DIM; j++) begin
      term = DW'(dprod[j]);
      if (m0n2[j] ^ cn2[j]) begin
        term = -term;
      end
      det_d = det_d + term;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      det_q <= det_d;
      cnd_q <= cn2;
      cad_q <= ca2;
    end
  end

  // Magnitude of the determinant, its sign folded into each cofactor sign.
  logic              ve_q;
  logic              sing_e_q;
  logic [DW-1:0]     dm_e_q;
  logic [N_ELEM-1:0] neg_e_q;
  logic [N_ELEM*CW-1:0] ca_e_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sing_e_q <= (det_q == '0);
      dm_e_q   <= det_q[DW-1] ? -det_q : det_q;
      neg_e_q  <= cnd_q ^ {N_ELEM{det_q[DW-1]}};
      ca_e_q   <= cad_q;
    end
  end

  // Reciprocal of the determinant magnitude.
  logic [QW-1:0] rcp;
  logic [S2-1:0] side2_d;
  logic [S2-1:0] side2_q;

  m3inv_div #(.DW(DW), .QW(QW)) u_div (
    .clk_i (clk_i),
    .en_i  (en),
    .dm_i  (dm_e_q),
    .q_o   (rcp)
  );

  assign side2_d = {ca_e_q, neg_e_q, sing_e_q, ve_q};

  m3inv_dly #(.WIDTH(S2), .DEPTH(QW)) u_dly_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .d_i    (side2_d),
    .d_o    (side2_q)
  );

  // Every cofactor magnitude scaled by the reciprocal.
  logic [PW-1:0] sprod [N_ELEM];
  logic [S3-1:0] side3_q;

  for (genvar gk = 0; gk < N_ELEM; gk++) begin : g_scale_mul
    m3inv_mul #(.AW(CW), .BW(QW)) u_mul (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   (side2_q[2+N_ELEM+gk*CW +: CW]),
      .b_i   (rcp),
      .p_o   (sprod[gk])
    );
  end

  m3inv_dly #(.WIDTH(S3), .DEPTH(MUL_LAT)) u_dly_scale (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .d_i    (side2_q[S3-1:0]),
    .d_o    (side3_q)
  );

  // Shift, saturate, negate and transpose.
  logic              v3;
  logic              sing3;
  logic [N_ELEM-1:0] neg3;
  logic [OW-1:0]     f_data_d;
  logic              f_ovf_d;
  logic              vf_q;
  logic [OW-1:0]     f_data_q;
  logic [USER_W-1:0] f_user_q;

  assign v3    = side3_q[0];
  assign sing3 = side3_q[1];
  assign neg3  = side3_q[2 +: N_ELEM];

  always_comb begin
    logic [QS-1:0] q;
    logic [QS-1:0] lim;
    logic [W-1:0]  mag;
    logic          over;
    f_data_d = '0;
    f_ovf_d  = 1'b0;
    for (int i = 0; i < N_DIM; i++) begin
      for (int j = 0; j < N_DIM; j++) begin
        q   = sprod[i*N_DIM+j][PW-1:SS];
        lim = (QS'(1) << (W-1)) - (neg3[i*N_DIM+j] ? QS'(0) : QS'(1));
        over = (q > lim);
        mag  = over ? lim[W-1:0] : q[W-1:0];
        if (!sing3) begin
          f_data_d[(j*N_DIM+i)*W +: W] = neg3[i*N_DIM+j] ? -mag : mag;
          f_ovf_d = f_ovf_d | over;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_data_q                <= f_data_d;
      f_user_q[USER_SINGULAR] <= sing3;
      f_user_q[USER_OVERFLOW] <= f_ovf_d;
    end
  end

  // Valid bits of the stages held in this module.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
      ve_q <= 1'b0;
      vf_q <= 1'b0;
    end else if (en) begin
      vd_q <= v2;
      ve_q <= vd_q;
      vf_q <= v3;
    end
  end

  // Output register with one skid entry. The pipeline runs while the skid
  // register is empty, so the enable comes straight from a flop.
  logic              out_v_q;
  logic [OW-1:0]     out_data_q;
  logic [USER_W-1:0] out_user_q;
  logic              skid_v_q;
  logic [OW-1:0]     skid_data_q;
  logic [USER_W-1:0] skid_user_q;

  assign en = ~skid_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (en) begin
      if (!out_v_q || m_axis_tready) begin
        out_v_q <= vf_q;
      end else if (vf_q) begin
        skid_v_q <= 1'b1;
      end
    end else if (m_axis_tready) begin
      skid_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (!out_v_q || m_axis_tready) begin
        out_data_q <= f_data_q;
        out_user_q <= f_user_q;
      end else begin
        skid_data_q <= f_data_q;
        skid_user_q <= f_user_q;
      end
    end else if (m_axis_tready) begin
      out_data_q <= skid_data_q;
      out_user_q <= skid_user_q;
    end
  end

  assign s_axis_tready = en;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = TDW'(out_data_q);
  assign m_axis_tuser  = out_user_q;

endmodule : mat3_inverse_cofactor

@@ sv/m3inv_chk.sv @@
// Port-level checks for the matrix inverse, bound to the top level.
module m3inv_chk import m3inv_pkg::*; #(
  parameter int OUT_TDW = 288
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               s_axis_tready,
  input logic [OUT_TDW-1:0] m_axis_tdata,
  input logic [USER_W-1:0]  m_axis_tuser,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready
);

  // A singular result is all zeros and never reports saturation.
  a_singular_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[USER_SINGULAR] |->
      (m_axis_tdata == '0) && !m_axis_tuser[USER_OVERFLOW])
    else $error("singular result carries data or overflow");

  // Input backpressure only appears while a result is waiting.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no result pending");

  // Once a result is taken, the skid entry is free and input opens again.
  a_reopen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready |=> s_axis_tready)
    else $error("input still stalled after a result was taken");

  // A stalled result holds its beat.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

endmodule : m3inv_chk

bind mat3_inverse_cofactor m3inv_chk #(.OUT_TDW(TDW)) u_m3inv_chk (.*);

@@ tb/testbench.sv @@
// Self-checking testbench for the pipelined 3x3 cofactor matrix inverse.
module testbench import m3inv_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W    = ELEM_WIDTH_DEF;
  localparam int F    = FRAC_BITS_DEF;
  localparam int TDW  = ((N_ELEM * W + 7) / 8) * 8;
  // Pipeline latency, waited out after the last result so that a stray beat is caught.
  localparam int LATENCY = 2 * F + 2 * W + 16;
  localparam int RECIP_SH = 2 * F + 2 * W + 2;
  localparam int SCALE_SH = 2 * W + 2;
  localparam int N_RANDOM = 1800;
  localparam logic [W-1:0] ONE = 1 << F;

  typedef logic signed [255:0] sbig_t;
  typedef logic [255:0] ubig_t;
  typedef logic [W-1:0] mat_t [N_ELEM];

  typedef struct {
    logic [W-1:0] elem [N_ELEM];
    logic [USER_W-1:0] flags;
  } inverse_t;

  // Holds the inverses still owed by the block and counts mismatches.
  class inverse_board;
    inverse_t owed [$];
    int errors = 0;

    // Adjugate times the truncated reciprocal of the determinant, truncated toward zero and saturated.
    function automatic inverse_t invert(mat_t m);
      inverse_t res;
      sbig_t a [3][3];
      sbig_t cof [3][3];
      sbig_t det;
      ubig_t dmag, recip, cmag, q, lim;
      logic neg;
      logic ovf;
      ovf = 1'b0;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) a[i][j] = $signed(m[i * 3 + j]);
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          cof[i][j] = a[(i + 1) % 3][(j + 1) % 3] * a[(i + 2) % 3][(j + 2) % 3]
                    - a[(i + 1) % 3][(j + 2) % 3] * a[(i + 2) % 3][(j + 1) % 3];
      det = a[0][0] * cof[0][0] + a[0][1] * cof[0][1] + a[0][2] * cof[0][2];
      res.flags = '0;
      if (det == 0) begin
        for (int k = 0; k < N_ELEM; k++) res.elem[k] = '0;
        res.flags[USER_SINGULAR] = 1'b1;
        return res;
      end
      dmag  = (det < 0) ? ubig_t'(-det) : ubig_t'(det);
      recip = (ubig_t'(1) << RECIP_SH) / dmag;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          neg  = (cof[i][j] < 0) != (det < 0);
          cmag = (cof[i][j] < 0) ? ubig_t'(-cof[i][j]) : ubig_t'(cof[i][j]);
          q    = (cmag * recip) >> SCALE_SH;
          lim  = neg ? (ubig_t'(1) << (W - 1)) : (ubig_t'(1) << (W - 1)) - 1;
          if (q > lim) begin
            q   = lim;
            ovf = 1'b1;
          end
          res.elem[j * 3 + i] = neg ? W'(-q) : W'(q);
        end
      end
      res.flags[USER_OVERFLOW] = ovf;
      return res;
    endfunction

    function void note_matrix(mat_t m);
      owed.push_back(invert(m));
    endfunction

    function void check_inverse(logic [TDW-1:0] data, logic [USER_W-1:0] flags);
      inverse_t exp;
      if (owed.size() == 0) begin
        $display("%0t: unexpected beat data=%h user=%b", $time, data, flags);
        errors++;
        return;
      end
      exp = owed.pop_front();
      for (int k = 0; k < N_ELEM; k++)
        if (data[k * W +: W] !== exp.elem[k]) begin
          $display("%0t: r%0d%0d expected %h actual %h", $time, k / 3, k % 3,
                   exp.elem[k], data[k * W +: W]);
          errors++;
        end
      if (flags[USER_SINGULAR] !== exp.flags[USER_SINGULAR]) begin
        $display("%0t: singular expected %b actual %b", $time,
                 exp.flags[USER_SINGULAR], flags[USER_SINGULAR]);
        errors++;
      end
      if (flags[USER_OVERFLOW] !== exp.flags[USER_OVERFLOW]) begin
        $display("%0t: overflowed expected %b actual %b", $time,
                 exp.flags[USER_OVERFLOW], flags[USER_OVERFLOW]);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic [TDW-1:0] s_axis_tdata = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [TDW-1:0] m_axis_tdata;
  logic [USER_W-1:0] m_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;

  inverse_board board = new();

  always #5 clk_i = ~clk_i;

  mat3_inverse_cofactor DUT (
    .clk_i, .rst_ni,
    .s_axis_tdata, .s_axis_tvalid, .s_axis_tready,
    .m_axis_tdata, .m_axis_tuser, .m_axis_tvalid, .m_axis_tready
  );

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Drives one matrix beat and holds it until the block takes it.
  task automatic send_matrix(mat_t m);
    int gap;
    for (int k = 0; k < N_ELEM; k++) s_axis_tdata[k * W +: W] <= m[k];
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_matrix(m);
    gap = gap_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic logic [W-1:0] small_val();
    return W'($signed($urandom_range(8 << F)) - $signed(4 << F));
  endfunction

  // Random content in one of several shapes; each reaches a different corner.
  function automatic mat_t random_matrix();
    mat_t m;
    int shape;
    shape = $urandom_range(9);
    for (int k = 0; k < N_ELEM; k++)
      m[k] = (shape < 3) ? W'($urandom()) : small_val();
    case (shape)
      3: begin
        // Singular: one row repeats another.
        for (int j = 0; j < 3; j++) m[6 + j] = m[j];
      end
      4: begin
        // Near-diagonal with tiny entries, so the inverse saturates.
        for (int k = 0; k < N_ELEM; k++) m[k] = W'($urandom_range(3));
        m[0] = $urandom_range(64, 1); m[4] = $urandom_range(64, 1);
        m[8] = $urandom_range(64, 1);
      end
      5: begin
        // Diagonal entries pushed eight units away from zero, usually well conditioned.
        m[0] = m[0] + (8 << F); m[4] = m[4] - (8 << F); m[8] = m[8] + (8 << F);
      end
      6: begin
        // Extreme magnitudes mixed with small ones.
        for (int k = 0; k < N_ELEM; k++)
          if ($urandom_range(1)) m[k] = $urandom_range(1) ? {1'b1, {(W-1){1'b0}}}
                                                           : {1'b0, {(W-1){1'b1}}};
      end
      default: ;
    endcase
    return m;
  endfunction

  function automatic mat_t diag(logic [W-1:0] a, logic [W-1:0] b, logic [W-1:0] c);
    mat_t m;
    for (int k = 0; k < N_ELEM; k++) m[k] = '0;
    m[0] = a; m[4] = b; m[8] = c;
    return m;
  endfunction

  function automatic mat_t fill(logic [W-1:0] v);
    mat_t m;
    for (int k = 0; k < N_ELEM; k++) m[k] = v;
    return m;
  endfunction

  // The receiver stalls at random, with long stretches of no stalls too.
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(30, 1)) @(posedge clk_i);
      stall = gap_len();
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i)
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      board.check_inverse(m_axis_tdata, m_axis_tuser);

  initial begin
    mat_t m;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: identity, scaled and negative diagonals, zero and extremes.
    send_matrix(diag(ONE, ONE, ONE));
    send_matrix(diag(ONE << 1, -(ONE << 2), ONE >> 1));
    send_matrix(diag(-ONE, -ONE, -ONE));
    send_matrix(fill('0));
    send_matrix(fill({1'b0, {(W-1){1'b1}}}));
    send_matrix(fill({1'b1, {(W-1){1'b0}}}));
    send_matrix(fill('1));
    send_matrix(diag(1, 1, 1));
    send_matrix(diag(1, -1, 1));
    send_matrix(diag({1'b0, {(W-1){1'b1}}}, {1'b0, {(W-1){1'b1}}},
                     {1'b0, {(W-1){1'b1}}}));
    send_matrix(diag({1'b1, {(W-1){1'b0}}}, {1'b1, {(W-1){1'b0}}},
                     {1'b1, {(W-1){1'b0}}}));
    // A permutation and a shear exercise every off-diagonal cofactor.
    m = fill('0); m[1] = ONE; m[5] = ONE; m[6] = ONE;
    send_matrix(m);
    m = diag(ONE, ONE, ONE); m[1] = ONE << 3; m[5] = -(ONE << 2); m[6] = ONE >> 3;
    send_matrix(m);
    // Rank one, so the determinant vanishes although no row is zero.
    for (int k = 0; k < N_ELEM; k++) m[k] = ((k / 3) + 1) * ((k % 3) + 1) * ONE;
    send_matrix(m);
    for (int k = 0; k < N_ELEM; k++) m[k] = W'($urandom());
    send_matrix(m);
    for (int k = 0; k < N_ELEM; k++) m[k] = ~m[k];
    send_matrix(m);

    for (int n = 0; n < N_RANDOM; n++) send_matrix(random_matrix());
    s_axis_tvalid <= 1'b0;

    while (board.owed.size() != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
    if (board.errors == 0)
      $display("mat3_inverse_cofactor test passed");
    else
      $display("mat3_inverse_cofactor test failed");
    $finish;
  end

  initial begin
    #5ms;
    $display("mat3_inverse_cofactor test failed");
    $finish;
  end

endmodule : testbench
